>>> sv/rsc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsc_pkg
// shared types and constants of the rgb555 sprite stream converter
// ---------------------------------------------------------------------------
package rsc_pkg;

	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic REG_DECODE_MODE  = 1'b0;
	localparam logic REG_PREFIX_BYTES = 1'b1;

	// decode modes
	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_RLE   = 2'd1;
	localparam logic [1:0] MODE_MIXED = 2'd2;

	localparam logic [7:0] CTRL_SKIP = 8'hFF;
	localparam logic [7:0] CTRL_NONE = 8'h00;

	typedef enum logic [2:0] {
		PH_START    = 3'd0,
		PH_RAW_HIGH = 3'd1,
		PH_SKIP     = 3'd2,
		PH_RUN_LOW  = 3'd3,
		PH_RUN_HIGH = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        is_pixel;
	} out_item_t;

	// classified word between parser and output stage
	typedef struct packed {
		logic        is_pixel;
		logic [15:0] value;
	} cmd_t;

endpackage

`default_nettype wire

>>> sv/rsc_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsc_front
// byte parser: tracks raw/run-length phase and classifies each byte
// ---------------------------------------------------------------------------
module rsc_front
	import rsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic       take,
	input  wire in_item_t   item,
	output logic            cmd_valid,
	output cmd_t            cmd
);

	logic [1:0]  decode_mode_q;
	logic [23:0] prefix_bytes_q;
	phase_t      phase_q, phase_n, ph;
	logic [7:0]  low_q, low_n;
	logic [7:0]  left_q, left_n;
	logic [23:0] prefix_q, prefix_n, pc, pc_inc;
	logic [7:0]  b;
	logic        rle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= MODE_RAW;
			prefix_bytes_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECODE_MODE:  decode_mode_q  <= cfg_data[1:0];
				REG_PREFIX_BYTES: prefix_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			low_q    <= '0;
			left_q   <= '0;
			prefix_q <= '0;
		end else if (take) begin
			phase_q  <= phase_n;
			low_q    <= low_n;
			left_q   <= left_n;
			prefix_q <= prefix_n;
		end
	end

	always_comb begin
		b        = item.data_byte;
		// image start clears the parser before the byte is taken
		ph       = item.image_start ? PH_START : phase_q;
		pc       = item.image_start ? 24'd0 : prefix_q;
		pc_inc   = (pc == '1) ? pc : pc + 24'd1;
		phase_n  = ph;
		low_n    = low_q;
		left_n   = item.image_start ? 8'd0 : left_q;
		prefix_n = pc;
		rle      = 1'b0;
		cmd_valid     = 1'b0;
		cmd.is_pixel  = 1'b0;
		cmd.value     = {8'd0, b};
		case (ph)
			PH_RAW_HIGH: begin
				prefix_n     = pc_inc;
				phase_n      = PH_START;
				cmd_valid    = 1'b1;
				cmd.is_pixel = 1'b1;
				cmd.value    = {b, low_q};
			end
			PH_SKIP: begin
				phase_n   = PH_START;
				cmd_valid = 1'b1;
			end
			PH_RUN_LOW: begin
				low_n   = b;
				phase_n = PH_RUN_HIGH;
			end
			PH_RUN_HIGH: begin
				left_n       = left_q - 8'd1;
				phase_n      = (left_n == 8'd0) ? PH_START : PH_RUN_LOW;
				cmd_valid    = 1'b1;
				cmd.is_pixel = 1'b1;
				cmd.value    = {b, low_q};
			end
			default: begin
				phase_n = PH_START;
				if (decode_mode_q == MODE_RLE)
					rle = 1'b1;
				else if (decode_mode_q == MODE_MIXED)
					rle = (pc >= prefix_bytes_q);
				if (!rle) begin
					prefix_n = pc_inc;
					low_n    = b;
					phase_n  = PH_RAW_HIGH;
				end else begin
					cmd_valid = 1'b1;
					if (b == CTRL_SKIP) begin
						phase_n = PH_SKIP;
					end else if (b != CTRL_NONE) begin
						left_n  = b;
						phase_n = PH_RUN_LOW;
					end
				end
			end
		endcase
	end

	// a run never sits in its pixel phases with nothing left to emit
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RUN_LOW || phase_q == PH_RUN_HIGH) |-> left_q != 8'd0)
		else $error("run phase with zero pixels left");

endmodule

`default_nettype wire

>>> sv/rsc_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsc_fifo
// short command queue between parser and output stage
// ---------------------------------------------------------------------------
module rsc_fifo
	import rsc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	input  wire logic rd_en,
	output cmd_t      rd_data,
	output logic      full,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + CW'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && empty))
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not follow a write");

endmodule

`default_nettype wire

>>> sv/rsc_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsc_back
// output stage: widens rgb555 pixels to argb8888, zero-extends control bytes and holds the result
// ---------------------------------------------------------------------------
module rsc_back
	import rsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_empty,
	input  wire cmd_t  cmd,
	output logic       cmd_rd,
	input  wire logic  pop,
	output logic       empty,
	output out_item_t  result
);

	logic      valid_q;
	out_item_t result_q;
	out_item_t conv;

	// each 5-bit channel gets its own top three bits appended
	function automatic logic [31:0] widen(input logic [15:0] c);
		widen = {8'hFF, c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
	endfunction

	always_comb begin
		conv.is_pixel = cmd.is_pixel;
		conv.out_word = cmd.is_pixel ? widen(cmd.value) : {24'd0, cmd.value[7:0]};
	end

	assign cmd_rd = !cmd_empty && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd_rd)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_rd)
			result_q <= conv;
	end

endmodule

`default_nettype wire

>>> sv/rgb555_sprite_rle_converter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb555_sprite_rle_converter
// rgb555 sprite byte stream to argb8888 words, raw / run-length / mixed
// ---------------------------------------------------------------------------
// a result word passes the command queue and then the output register to the result ports
// throughput: one byte per cycle while full is low, set by the byte parser
// full rises only when the command queue (DEPTH entries) and output stage fill
// reset (arst_n low) clears parser, queue, output stage and both registers
module rgb555_sprite_rle_converter
	import rsc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire in_item_t    item,
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        result
);

	logic take;
	logic cmd_valid;
	cmd_t cmd_in, cmd_out;
	logic q_empty, q_rd;

	assign take = push && !full;

	rsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	rsc_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take && cmd_valid),
		.wr_data (cmd_in),
		.rd_en   (q_rd),
		.rd_data (cmd_out),
		.full    (full),
		.empty   (q_empty)
	);

	rsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (cmd_out),
		.cmd_rd    (q_rd),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

>>> verif/rgb555_sprite_rle_converter_tb.sv
// ---------------------------------------------------------------------------
// rgb555_sprite_rle_converter_tb
// feeds sprite byte streams in raw, run-length and mixed mode, predicts every
// argb8888 / control word in the testbench and checks each popped transaction
// ---------------------------------------------------------------------------
module rgb555_sprite_rle_converter_tb;
	import rsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_BYTES = 1750;
	localparam int PHASE_BYTES  = 150;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;
	logic        push;
	logic        full;
	in_item_t    item;
	logic        empty;
	logic        pop;
	out_item_t   result;

	rgb555_sprite_rle_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// predictor copy of registers and parser
	logic [1:0]  mode_q;
	logic [23:0] prefix_len;
	phase_t      parse_at;
	logic [7:0]  low_hold;
	logic [7:0]  run_left;
	logic [23:0] prefix_seen;

	out_item_t expected_words[$];

	int n_errors;
	int n_bytes;
	int n_pixels;
	int n_ctrl;
	int n_cfg_writes;
	int n_images;
	int idle_cycles;
	bit send_steady;
	int img_left;
	bit img_first;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] widen_rgb555(input logic [15:0] c);
		return {8'hFF, c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic bump_prefix();
		if (prefix_seen != 24'hFFFFFF)
			prefix_seen = prefix_seen + 24'd1;
	endtask

	task automatic predict_byte(input in_item_t it);
		logic rle;
		if (it.image_start) begin
			parse_at = PH_START;
			low_hold = '0;
			run_left = '0;
			prefix_seen = '0;
		end
		case (parse_at)
			PH_RAW_HIGH: begin
				bump_prefix();
				parse_at = PH_START;
				expected_words.push_back('{widen_rgb555({it.data_byte, low_hold}), 1'b1});
			end
			PH_SKIP: begin
				parse_at = PH_START;
				expected_words.push_back('{{24'd0, it.data_byte}, 1'b0});
			end
			PH_RUN_LOW: begin
				low_hold = it.data_byte;
				parse_at = PH_RUN_HIGH;
			end
			PH_RUN_HIGH: begin
				run_left = run_left - 8'd1;
				parse_at = (run_left == 8'd0) ? PH_START : PH_RUN_LOW;
				expected_words.push_back('{widen_rgb555({it.data_byte, low_hold}), 1'b1});
			end
			default: begin
				// waiting for a control byte or the low byte of a raw pixel
				parse_at = PH_START;
				rle = (mode_q == MODE_RLE) ||
					(mode_q == MODE_MIXED && prefix_seen >= prefix_len);
				if (!rle) begin
					bump_prefix();
					low_hold = it.data_byte;
					parse_at = PH_RAW_HIGH;
				end else begin
					expected_words.push_back('{{24'd0, it.data_byte}, 1'b0});
					if (it.data_byte == CTRL_SKIP) begin
						parse_at = PH_SKIP;
					end else if (it.data_byte != CTRL_NONE) begin
						run_left = it.data_byte;
						parse_at = PH_RUN_LOW;
					end
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic st);
		in_item_t it;
		int gap;
		it = '{data_byte: b, image_start: st};
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		predict_byte(it);
		n_bytes++;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// sender stops and waits until every expected word has been popped
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		// low bytes give no word but may still be inside the block
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		if (idx == REG_DECODE_MODE)
			mode_q = d[1:0];
		else
			prefix_len = d;
		n_cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [1:0] mode, input logic [23:0] plen);
		logic [23:0] mode_word;
		mode_word = 24'($urandom);
		mode_word[1:0] = mode;
		if ($urandom_range(0, 1)) begin
			write_reg(REG_DECODE_MODE, mode_word);
			write_reg(REG_PREFIX_BYTES, plen);
		end else begin
			write_reg(REG_PREFIX_BYTES, plen);
			write_reg(REG_DECODE_MODE, mode_word);
		end
	endtask

	task automatic send_pixel(input logic [15:0] px, input logic st);
		send_byte(px[7:0], st);
		send_byte(px[15:8], 1'b0);
	endtask

	// byte of a generated image; stops once a truncated image is used up
	task automatic img_byte(input logic [7:0] b);
		if (img_left != 0) begin
			send_byte(b, img_first);
			img_first = 1'b0;
			img_left--;
		end
	endtask

	task automatic send_image(input int units);
		int r;
		int n;
		img_first = 1'b1;
		img_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 32'h7FFFFFFF;
		send_steady = ($urandom_range(0, 4) == 0);
		n_images++;
		if (mode_q == MODE_RLE || (mode_q == MODE_MIXED && prefix_len <= 24'd64)) begin
			if (mode_q == MODE_MIXED)
				repeat ((prefix_len + 1) & ~1) img_byte(8'($urandom));
			repeat (units) begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					img_byte(CTRL_SKIP);
					img_byte(8'($urandom));
				end else if (r < 22) begin
					img_byte(CTRL_NONE);
				end else begin
					n = (r < 23) ? $urandom_range(1, 254) : $urandom_range(1, 6);
					img_byte(8'(n));
					repeat (2 * n) img_byte(8'($urandom));
				end
			end
		end else begin
			repeat (2 * units) img_byte(8'($urandom));
		end
		send_steady = 1'b0;
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	task automatic test_raw_extremes();
		configure(MODE_RAW, 24'd0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h7C00, 1'b0);
		send_pixel(16'h03E0, 1'b0);
		send_pixel(16'h001F, 1'b0);
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'h5555, 1'b0);
		send_pixel(16'hAAAA, 1'b0);
	endtask

	task automatic test_rle_controls();
		drain();
		configure(MODE_RLE, 24'd0);
		send_byte(CTRL_NONE, 1'b1);
		send_byte(CTRL_SKIP, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(CTRL_SKIP, 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(8'd2, 1'b0);
		send_pixel(16'h7FFF, 1'b0);
		send_pixel(16'h1234, 1'b0);
		// new image cuts a run short
		send_byte(8'd3, 1'b0);
		send_pixel(16'h4321, 1'b0);
		send_byte(8'd1, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		drain();
		// unused mode value falls back to raw
		configure(2'd3, 24'hFFFFFF);
		send_pixel(16'hC3A5, 1'b1);
	endtask

	task automatic test_mixed_prefix();
		drain();
		configure(MODE_MIXED, 24'd3);
		// odd prefix ends on a whole pixel
		send_pixel(16'h0421, 1'b1);
		send_pixel(16'h7BDE, 1'b0);
		send_byte(8'd1, 1'b0);
		send_pixel(16'h2A55, 1'b0);
		send_byte(CTRL_SKIP, 1'b0);
		send_byte(8'd7, 1'b0);
		drain();
		configure(MODE_MIXED, 24'd0);
		send_byte(CTRL_NONE, 1'b1);
		send_byte(8'd1, 1'b0);
		send_pixel(16'h0001, 1'b0);
	endtask

	task automatic test_mode_switch();
		drain();
		configure(MODE_RAW, 24'd0);
		send_byte(8'h9C, 1'b1);
		drain();
		// half-built pixel completes before the new mode applies
		write_reg(REG_DECODE_MODE, {22'd0, MODE_RLE});
		send_byte(8'h63, 1'b0);
		send_byte(CTRL_SKIP, 1'b0);
		drain();
		write_reg(REG_DECODE_MODE, {22'd0, MODE_RAW});
		send_byte(8'd9, 1'b0);
		send_pixel(16'h3C0F, 1'b0);
	endtask

	task automatic test_random_streams();
		int start_bytes;
		int phase_end;
		logic [1:0] mode;
		logic [23:0] plen;
		start_bytes = n_bytes;
		while (n_bytes < start_bytes + RANDOM_BYTES) begin
			drain();
			mode = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) :
				($urandom_range(0, 1) ? MODE_RLE : MODE_MIXED);
			case ($urandom_range(0, 5))
				0: plen = 24'd0;
				1: plen = 24'hFFFFFF;
				2: plen = 24'($urandom);
				default: plen = 24'($urandom_range(1, 13));
			endcase
			configure(mode, plen);
			phase_end = n_bytes + PHASE_BYTES;
			while (n_bytes < phase_end) begin
				if ($urandom_range(0, 99) < 85)
					send_image($urandom_range(1, 8));
				else
					send_noise($urandom_range(1, 10));
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$error("unexpected transaction: out_word %h is_pixel %b",
					result.out_word, result.is_pixel);
				n_errors++;
			end else begin
				want = expected_words.pop_front();
				if (result.out_word !== want.out_word) begin
					$error("out_word: expected %h, actual %h", want.out_word, result.out_word);
					n_errors++;
				end
				if (result.is_pixel !== want.is_pixel) begin
					$error("is_pixel: expected %b, actual %b", want.is_pixel, result.is_pixel);
					n_errors++;
				end
				if (want.is_pixel)
					n_pixels++;
				else
					n_ctrl++;
			end
		end
	end

	// receiver stalls
	initial begin
		int stall;
		bit steady;
		stall = 0;
		steady = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				steady = !steady;
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = steady ? 0 : pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("rgb555_sprite_rle_converter regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		mode_q = MODE_RAW;
		prefix_len = '0;
		parse_at = PH_START;
		low_hold = '0;
		run_left = '0;
		prefix_seen = '0;
		n_errors = 0;
		n_bytes = 0;
		n_pixels = 0;
		n_ctrl = 0;
		n_cfg_writes = 0;
		n_images = 0;
		idle_cycles = 0;
		send_steady = 1'b0;
		img_left = 0;
		img_first = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_raw_extremes();
		test_rle_controls();
		test_mixed_prefix();
		test_mode_switch();
		test_random_streams();

		@(negedge clk);
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			n_errors += expected_words.size();
		end

		$display("covered %0d bytes in %0d generated images, %0d register writes",
			n_bytes, n_images, n_cfg_writes);
		$display("checked %0d pixel words and %0d control words, %0d mismatches",
			n_pixels, n_ctrl, n_errors);
		if (n_errors == 0)
			$display("rgb555_sprite_rle_converter regression: pass");
		else
			$display("rgb555_sprite_rle_converter regression: fail");
		$finish;
	end

endmodule
